>>> rtl/snsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stereo noise-shaped dither requantizer.
// No dependencies; imported by every module of the block.
package snsd_pkg;

  localparam int OUT_BITS    = 16;
  localparam int FRAC_BITS   = 28;
  localparam int SAMPLE_W    = 32;
  localparam int SHIFT       = FRAC_BITS + 1 - OUT_BITS;
  localparam int LEVEL_W     = FRAC_BITS + 1;
  localparam int OVER_W      = 31;
  localparam int TALLY_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] LCG_MUL    = 32'h0019_660D;
  localparam logic [31:0] LCG_ADD    = 32'h3C6E_F35F;
  localparam logic [31:0] DITH_MASK  = (32'd1 << SHIFT) - 32'd1;
  localparam logic [31:0] ROUND_BIAS = 32'd1 << (FRAC_BITS - OUT_BITS);
  localparam logic [31:0] DITH_RESET = ROUND_BIAS + (LCG_ADD & DITH_MASK);
  localparam logic signed [31:0] CLIP_HI = signed'((32'd1 << FRAC_BITS) - 32'd1);
  localparam logic signed [31:0] CLIP_LO = signed'(32'd0 - (32'd1 << FRAC_BITS));
  localparam logic [LEVEL_W-1:0] PEAK_MAX = LEVEL_W'(32'd1 << FRAC_BITS);
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] left_pcm;
    logic signed [OUT_BITS-1:0] right_pcm;
    logic                       frame_end_out;
    logic [TALLY_W-1:0]         clipped_total;
    logic [LEVEL_W-1:0]         peak_level;
    logic [OVER_W-1:0]          peak_overshoot;
  } out_item_t;

  // One channel's classified result, handed from the front to the statistics.
  typedef struct packed {
    logic signed [OUT_BITS-1:0] pcm;
    logic signed [LEVEL_W-1:0]  level;
    logic                       clip_hi;
    logic                       clip_lo;
    logic [OVER_W-1:0]          over;
  } chan_res_t;

  typedef struct packed {
    chan_res_t left_ch;
    chan_res_t right_ch;
    logic      frame_end;
  } mid_item_t;

endpackage

>>> rtl/stereo_noise_shaped_dither_to_pcm16_core.sv
`timescale 1ns / 1ps
// Top level of the stereo noise-shaped dither requantizer to 16-bit PCM.
// Depends on snsd_pkg, snsd_chan, snsd_queue and snsd_stats.
//
// Usage
//   Input side is a queue: drive pair and raise push; the item is taken at a
//   rising edge where push is high and full is low. Output side is a queue:
//   while empty is low, result holds the oldest finished item; it leaves at
//   an edge where pop is high and empty is low.
//   Each item is a stereo pair with 28 fraction bits; each result carries the
//   two dithered PCM samples, the frame_end copy and the running statistics
//   (clip count, peak level, peak overshoot) after both channels.
// Timing
//   An accepted item is written into the queue, moves into the result
//   register once that is free, and can leave from there. Throughput is one
//   item per cycle while pop stays high: the two channel fronts close their
//   error feedback and generator loops combinationally into their registers,
//   and the statistics back end updates left then right in one pass.
// Reset
//   rst (synchronous, active high) clears the shaping taps, seeds the dither
//   generators, zeroes the statistics and empties both queues.
// Stalls
//   When pop stays low the result register holds; the two-entry queue keeps
//   taking items until it fills, then full rises and input stalls.
module stereo_noise_shaped_dither_to_pcm16_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  snsd_pkg::in_item_t  pair,
  output logic                empty,
  input  logic                pop,
  output snsd_pkg::out_item_t result
);
  import snsd_pkg::*;

  logic      accept;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  chan_res_t l_res;
  chan_res_t r_res;
  mid_item_t mid_in;
  mid_item_t mid_out;

  // take an item only while the queue has room
  assign accept = push & ~q_full;
  assign full   = q_full;

  // front: both channels advance together on every accepted item
  snsd_chan u_left (
    .clk    (clk),
    .rst    (rst),
    .adv    (accept),
    .sample (pair.left_sample),
    .res    (l_res)
  );

  snsd_chan u_right (
    .clk    (clk),
    .rst    (rst),
    .adv    (accept),
    .sample (pair.right_sample),
    .res    (r_res)
  );

  assign mid_in.left_ch   = l_res;
  assign mid_in.right_ch  = r_res;
  assign mid_in.frame_end = pair.frame_end;

  // hold classified items until the back end is free
  snsd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .wr_item (mid_in),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (mid_out),
    .empty   (q_empty)
  );

  // back: statistics and the result register
  snsd_stats u_stats (
    .clk    (clk),
    .rst    (rst),
    .avail  (~q_empty),
    .item   (mid_out),
    .take   (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  // an item pushed without a simultaneous drain must be waiting next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (accept && !q_pop) |=> !q_empty)
    else $error("accepted item did not reach the queue");

  // a free result register must pick up a waiting item
  a_back_moves: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && empty) |=> !empty)
    else $error("back end left a waiting item in the queue");

  // reset drops every result
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result shown straight after reset");

  // the tracked peak never exceeds full scale
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.peak_level <= PEAK_MAX))
    else $error("peak level above full scale");

endmodule

>>> rtl/snsd_queue.sv
`timescale 1ns / 1ps
// Short queue between the requantizing front and the statistics back end.
// Depends on snsd_pkg for the item type and depth.
module snsd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  snsd_pkg::mid_item_t wr_item,
  output logic                full,
  input  logic                pop,
  output snsd_pkg::mid_item_t rd_item,
  output logic                empty
);
  import snsd_pkg::*;

  mid_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/snsd_chan.sv
`timescale 1ns / 1ps
// One channel of the front: noise shaping, dither, clip and error feedback.
// Depends on snsd_pkg for constants and the chan_res_t result type.
module snsd_chan (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic signed [snsd_pkg::SAMPLE_W-1:0] sample,
  output snsd_pkg::chan_res_t              res
);
  import snsd_pkg::*;

  // e_new, e_mid as in the shaping filter; p_diff holds e_old - e_mid
  logic [31:0] e_new;
  logic [31:0] e_mid;
  logic [31:0] p_diff;
  // lcg holds the generator value for the coming item; dith its bias + dither
  logic [31:0] lcg;
  logic [31:0] dith;

  logic [31:0] smp;
  logic [31:0] o;
  logic [31:0] smp_c;
  logic [31:0] o_c;
  logic [31:0] o_m;
  logic [31:0] e_half;
  logic [31:0] over32;
  logic [31:0] e_new_next;
  logic [31:0] lcg_next;
  logic [31:0] dith_next;
  logic        clip_hi;
  logic        clip_lo;

  always_comb begin
    smp     = $unsigned(sample) + e_new + p_diff;
    o       = smp + dith;
    clip_hi = ($signed(o) > CLIP_HI);
    clip_lo = ($signed(o) < CLIP_LO);
    if (clip_hi) begin
      o_c = CLIP_HI;
    end else if (clip_lo) begin
      o_c = CLIP_LO;
    end else begin
      o_c = o;
    end
    if (clip_hi && ($signed(smp) > CLIP_HI)) begin
      smp_c = CLIP_HI;
    end else if (clip_lo && ($signed(smp) < CLIP_LO)) begin
      smp_c = CLIP_LO;
    end else begin
      smp_c = smp;
    end
    o_m        = o_c & ~DITH_MASK;
    e_new_next = smp_c - o_m;
    // halve toward zero: bias negatives by one before the arithmetic shift
    e_half     = $unsigned($signed(e_new + {31'd0, e_new[31]}) >>> 1);
    over32     = clip_hi ? (o - CLIP_HI) : (CLIP_LO - o);
    lcg_next   = lcg * LCG_MUL + LCG_ADD;
    dith_next  = ROUND_BIAS + (lcg_next & DITH_MASK) - (lcg & DITH_MASK);
  end

  always_comb begin
    res.pcm     = o_m[FRAC_BITS -: OUT_BITS];
    res.level   = o_c[LEVEL_W-1:0];
    res.clip_hi = clip_hi;
    res.clip_lo = clip_lo;
    res.over    = over32[OVER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_new  <= '0;
      e_mid  <= '0;
      p_diff <= '0;
      lcg    <= LCG_ADD;
      dith   <= DITH_RESET;
    end else if (adv) begin
      e_new  <= e_new_next;
      e_mid  <= e_half;
      p_diff <= e_mid - e_half;
      lcg    <= lcg_next;
      dith   <= dith_next;
    end
  end

endmodule

>>> rtl/snsd_stats.sv
`timescale 1ns / 1ps
// Back end: shared clip statistics, left channel then right, and the result register.
// Depends on snsd_pkg for item types and statistic widths.
module snsd_stats (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  snsd_pkg::mid_item_t item,
  output logic                take,
  input  logic                pop,
  output logic                empty,
  output snsd_pkg::out_item_t result
);
  import snsd_pkg::*;

  typedef struct packed {
    logic [TALLY_W-1:0] tally;
    logic [LEVEL_W-1:0] peak;
    logic [OVER_W-1:0]  over;
  } stat_t;

  stat_t     stats;
  stat_t     mid_stats;
  stat_t     stats_next;
  logic      loaded;
  out_item_t result_next;

  function automatic stat_t stat_step(stat_t s, chan_res_t c);
    stat_t              n;
    logic signed [LEVEL_W:0] lvl;
    logic signed [LEVEL_W:0] pk;
    logic signed [LEVEL_W:0] neg_lvl;
    logic               pos;
    logic               neg;
    logic               clip;
    n       = s;
    lvl     = {c.level[LEVEL_W-1], c.level};
    pk      = {1'b0, s.peak};
    neg_lvl = -lvl;
    clip    = c.clip_hi | c.clip_lo;
    pos     = c.clip_hi | (~c.clip_lo & (lvl >= pk));
    neg     = ~pos & (c.clip_lo | (lvl < -pk));
    if (pos) begin
      n.peak = $unsigned(c.level);
    end else if (neg) begin
      n.peak = neg_lvl[LEVEL_W-1:0];
    end
    if (clip && (s.tally != TALLY_MAX)) begin
      n.tally = s.tally + 1'b1;
    end
    if (clip && (c.over > s.over)) begin
      n.over = c.over;
    end
    return n;
  endfunction

  assign take  = avail & (~loaded | pop);
  assign empty = ~loaded;

  always_comb begin
    mid_stats                 = stat_step(stats, item.left_ch);
    stats_next                = stat_step(mid_stats, item.right_ch);
    result_next.left_pcm       = item.left_ch.pcm;
    result_next.right_pcm      = item.right_ch.pcm;
    result_next.frame_end_out  = item.frame_end;
    result_next.clipped_total  = stats_next.tally;
    result_next.peak_level     = stats_next.peak;
    result_next.peak_overshoot = stats_next.over;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      stats  <= '0;
    end else if (take) begin
      loaded <= 1'b1;
      stats  <= stats_next;
    end else if (pop) begin
      loaded <= 1'b0;
    end
  end

endmodule
